// ----- sv/rtpr_pkg.sv -----
// shared types and constants of the rtp reorder buffer
package rtpr_pkg;

	localparam int TIME_W = 48;
	localparam int HANDLE_W = 16;
	localparam int SEQ_W = 16;
	localparam int CFG_PK_W = 9;
	localparam int CFG_MS_W = 16;
	localparam int CFG_SEC_W = 12;
	localparam int LIMIT_W = 22;
	localparam int MS_PER_SEC = 1000;

	// input kinds
	localparam logic [1:0] KIND_PUSH = 2'd0;
	localparam logic [1:0] KIND_POP = 2'd1;

	// result status codes
	localparam logic [2:0] ST_STORED = 3'd0;
	localparam logic [2:0] ST_DROPPED = 3'd1;
	localparam logic [2:0] ST_RESTARTED = 3'd2;
	localparam logic [2:0] ST_TOO_FAR = 3'd3;
	localparam logic [2:0] ST_POPPED = 3'd4;
	localparam logic [2:0] ST_NONE = 3'd5;
	localparam logic [2:0] ST_TIMEOUT = 3'd6;
	localparam logic [2:0] ST_COUNT = 3'd7;

	// register indexes
	localparam logic [1:0] REG_WALL_PK = 2'd0;
	localparam logic [1:0] REG_WALL_MS = 2'd1;
	localparam logic [1:0] REG_BROKEN = 2'd2;

	// register reset values
	localparam logic [CFG_PK_W-1:0] RST_WALL_PK = 9'd100;
	localparam logic [CFG_MS_W-1:0] RST_WALL_MS = 16'd500;
	localparam logic [CFG_SEC_W-1:0] RST_BROKEN = 12'd5;

	// one slot of the packet store
	typedef struct packed {
		logic valid;
		logic [TIME_W-1:0] arrival;
		logic [HANDLE_W-1:0] handle;
	} slot_t;

endpackage

// ----- sv/rtp_reorder_buffer_core.sv -----
// rtp reorder buffer: slot memory, push/pop sequencer and register port
// path to the result beat: query, drop, too far and empty pop go straight to the output,
//   store or duplicate read the slot back first, a pop scans up to the lowest packet first
// a flush adds a clearing pass, then a restart stores the new packet in slot zero
// one item in flight; s_tready returns the cycle after the result beat is loaded
// reset: registers take their defaults, then a clearing pass over all DEPTH slots with s_tready low
module rtp_reorder_buffer_core #(
	parameter int DEPTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	// in: now_ms[47:0], seq_number[63:48], packet_handle[79:64], force_req[80]
	input  logic [87:0] s_tdata,
	// in: kind[1:0]
	input  logic [1:0] s_tuser,
	input  logic s_tvalid,
	output logic s_tready,
	// out: packet_handle_out[15:0], seq_out[31:16], flushed[32], stored_count from bit 33
	output logic [((33 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata,
	// out: status[2:0]
	output logic [2:0] m_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int OUT_W = ((33 + CW + 7) / 8) * 8;
	localparam int TW = rtpr_pkg::TIME_W;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_EXEC, S_PUSH_CHK, S_SCAN, S_RESTORE, S_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [rtpr_pkg::CFG_PK_W-1:0] wall_pk_q;
	logic [rtpr_pkg::CFG_MS_W-1:0] wall_ms_q;
	logic [rtpr_pkg::CFG_SEC_W-1:0] broken_q;
	logic [rtpr_pkg::LIMIT_W-1:0] limit_q;

	// block state
	logic started_q;
	logic [TW-1:0] exp_q;
	logic [TW-1:0] last_q;
	logic [IW-1:0] base_q;
	logic [CW-1:0] cnt_q;

	// accepted item
	logic [1:0] kind_q;
	logic [TW-1:0] now_q;
	logic [rtpr_pkg::SEQ_W-1:0] seq_q;
	logic [rtpr_pkg::HANDLE_W-1:0] hdl_q;
	logic force_q;

	// result in preparation
	logic [2:0] res_status_q;
	logic [rtpr_pkg::HANDLE_W-1:0] res_hdl_q;
	logic [rtpr_pkg::SEQ_W-1:0] res_seq_q;
	logic res_flushed_q;

	// sweep and scan control
	logic [IW-1:0] clr_addr_q;
	logic clr_then_out_q;
	logic restart_q;
	logic [IW-1:0] push_idx_q;
	logic [IW-1:0] scan_idx_q;
	logic [IW-1:0] scan_off_q;
	logic rv_s1;
	logic [IW-1:0] idx_s1;
	logic [IW-1:0] off_s1;

	// output register
	logic [OUT_W-1:0] m_tdata_q;
	logic [2:0] m_tuser_q;
	logic m_tvalid_q;

	// slot memory
	rtpr_pkg::slot_t mem [DEPTH];
	rtpr_pkg::slot_t rdata_q;
	logic mem_we;
	logic [IW-1:0] mem_waddr;
	logic [IW-1:0] mem_raddr;
	rtpr_pkg::slot_t mem_wdata;

	// execution decode
	logic in_acc;
	logic cfg_wr;
	logic use_item;
	logic [TW-1:0] eff_exp;
	logic [TW-1:0] eff_last;
	logic silent;
	logic [rtpr_pkg::SEQ_W-1:0] d16;
	logic d_neg;
	logic [16:0] neg_d;
	logic under;
	logic too_far;
	logic [IW:0] idx_sum;
	logic [IW-1:0] push_idx;
	logic age_over;
	logic go;
	logic [TW-1:0] pop_seq;
	logic [IW-1:0] idx_next;
	logic [IW-1:0] scan_next;

	assign in_acc = s_tvalid && s_tready;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign s_tready = (state_q == S_IDLE);
	assign pready = 1'b1;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;
	assign m_tvalid = m_tvalid_q;

	// register read
	always_comb begin
		case (paddr[3:2])
			rtpr_pkg::REG_WALL_PK: prdata = 32'(wall_pk_q);
			rtpr_pkg::REG_WALL_MS: prdata = 32'(wall_ms_q);
			rtpr_pkg::REG_BROKEN: prdata = 32'(broken_q);
			default: prdata = 32'd0;
		endcase
	end

	// widening against the expected sequence and the silence check
	always_comb begin
		use_item = !started_q && (kind_q == rtpr_pkg::KIND_PUSH);
		eff_exp = use_item ? TW'(seq_q) : exp_q;
		eff_last = use_item ? now_q : last_q;
		silent = (now_q > eff_last) && ((now_q - eff_last) > TW'(limit_q));
		d16 = seq_q - eff_exp[rtpr_pkg::SEQ_W-1:0];
		d_neg = d16[rtpr_pkg::SEQ_W-1];
		neg_d = 17'h10000 - {1'b0, d16};
		under = d_neg && (eff_exp < TW'(neg_d));
		too_far = !d_neg && (32'(d16) >= 32'(DEPTH));
		idx_sum = (IW + 1)'(base_q) + (IW + 1)'(d16[IW-1:0]);
		push_idx = (idx_sum >= (IW + 1)'(DEPTH)) ? IW'(idx_sum - (IW + 1)'(DEPTH))
			: idx_sum[IW-1:0];
	end

	// release decision on the lowest stored slot
	always_comb begin
		age_over = (now_q > rdata_q.arrival) &&
			((now_q - rdata_q.arrival) > TW'(wall_ms_q));
		go = (off_s1 == '0) || (32'(cnt_q) > 32'(wall_pk_q)) || age_over || force_q;
		pop_seq = exp_q + TW'(off_s1);
		idx_next = (idx_s1 == IW'(DEPTH - 1)) ? '0 : idx_s1 + 1'b1;
		scan_next = (scan_idx_q == IW'(DEPTH - 1)) ? '0 : scan_idx_q + 1'b1;
	end

	// memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = clr_addr_q;
		mem_wdata = '0;
		mem_raddr = scan_idx_q;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_EXEC: begin
				mem_raddr = push_idx;
			end
			S_PUSH_CHK: begin
				mem_we = !rdata_q.valid;
				mem_waddr = push_idx_q;
				mem_wdata = '{valid: 1'b1, arrival: now_q, handle: hdl_q};
			end
			S_RESTORE: begin
				mem_we = 1'b1;
				mem_waddr = '0;
				mem_wdata = '{valid: 1'b1, arrival: now_q, handle: hdl_q};
			end
			S_SCAN: begin
				mem_we = rv_s1 && rdata_q.valid && go;
				mem_waddr = idx_s1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// slot memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	// configuration registers, zero writes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_pk_q <= rtpr_pkg::RST_WALL_PK;
			wall_ms_q <= rtpr_pkg::RST_WALL_MS;
			broken_q <= rtpr_pkg::RST_BROKEN;
			limit_q <= rtpr_pkg::LIMIT_W'(rtpr_pkg::RST_BROKEN) *
				rtpr_pkg::LIMIT_W'(rtpr_pkg::MS_PER_SEC);
		end else if (cfg_wr) begin
			case (paddr[3:2])
				rtpr_pkg::REG_WALL_PK: begin
					if (pwdata[8:0] != '0) wall_pk_q <= pwdata[8:0];
				end
				rtpr_pkg::REG_WALL_MS: begin
					if (pwdata[15:0] != '0) wall_ms_q <= pwdata[15:0];
				end
				rtpr_pkg::REG_BROKEN: begin
					if (pwdata[11:0] != '0) begin
						broken_q <= pwdata[11:0];
						limit_q <= rtpr_pkg::LIMIT_W'(pwdata[11:0]) *
							rtpr_pkg::LIMIT_W'(rtpr_pkg::MS_PER_SEC);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// item payload capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q <= s_tuser;
			now_q <= s_tdata[47:0];
			seq_q <= s_tdata[63:48];
			hdl_q <= s_tdata[79:64];
			force_q <= s_tdata[80];
		end
	end

	// sequencer, block state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			started_q <= 1'b0;
			exp_q <= '0;
			last_q <= '0;
			base_q <= '0;
			cnt_q <= '0;
			clr_addr_q <= '0;
			clr_then_out_q <= 1'b0;
			restart_q <= 1'b0;
			rv_s1 <= 1'b0;
			m_tvalid_q <= 1'b0;
			res_status_q <= rtpr_pkg::ST_COUNT;
			res_hdl_q <= '0;
			res_seq_q <= '0;
			res_flushed_q <= 1'b0;
			push_idx_q <= '0;
			scan_idx_q <= '0;
			scan_off_q <= '0;
			idx_s1 <= '0;
			off_s1 <= '0;
			m_tdata_q <= '0;
			m_tuser_q <= '0;
		end else begin
			if (m_tready && state_q != S_OUT) m_tvalid_q <= 1'b0;
			case (state_q)
				// memory clearing pass
				S_CLEAR: begin
					if (clr_addr_q == IW'(DEPTH - 1)) begin
						clr_addr_q <= '0;
						if (restart_q) state_q <= S_RESTORE;
						else if (clr_then_out_q) state_q <= S_OUT;
						else state_q <= S_IDLE;
					end else begin
						clr_addr_q <= clr_addr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (in_acc) state_q <= S_EXEC;
				end
				S_EXEC: begin
					res_hdl_q <= '0;
					res_seq_q <= '0;
					clr_then_out_q <= 1'b1;
					restart_q <= (kind_q == rtpr_pkg::KIND_PUSH) && (silent || under);
					res_flushed_q <= ((kind_q == rtpr_pkg::KIND_PUSH) && (silent || under)) ||
						((kind_q == rtpr_pkg::KIND_POP) && silent);
					if (kind_q == rtpr_pkg::KIND_PUSH) begin
						started_q <= 1'b1;
						if (use_item || silent || under) begin
							exp_q <= TW'(seq_q);
							last_q <= now_q;
						end
						if (silent || under) begin
							// flush, then store as the new expected packet in slot zero
							base_q <= '0;
							cnt_q <= '0;
							res_status_q <= rtpr_pkg::ST_RESTARTED;
							state_q <= S_CLEAR;
						end else if (d_neg) begin
							res_status_q <= rtpr_pkg::ST_DROPPED;
							state_q <= S_OUT;
						end else if (too_far) begin
							res_status_q <= rtpr_pkg::ST_TOO_FAR;
							state_q <= S_OUT;
						end else begin
							push_idx_q <= push_idx;
							state_q <= S_PUSH_CHK;
						end
					end else if (kind_q == rtpr_pkg::KIND_POP) begin
						if (silent) begin
							cnt_q <= '0;
							res_status_q <= rtpr_pkg::ST_TIMEOUT;
							state_q <= S_CLEAR;
						end else if (cnt_q == '0) begin
							res_status_q <= rtpr_pkg::ST_NONE;
							state_q <= S_OUT;
						end else begin
							scan_idx_q <= base_q;
							scan_off_q <= '0;
							rv_s1 <= 1'b0;
							state_q <= S_SCAN;
						end
					end else begin
						res_status_q <= rtpr_pkg::ST_COUNT;
						state_q <= S_OUT;
					end
				end
				// slot read back: duplicate or free
				S_PUSH_CHK: begin
					if (rdata_q.valid) begin
						res_status_q <= rtpr_pkg::ST_DROPPED;
					end else begin
						res_status_q <= rtpr_pkg::ST_STORED;
						cnt_q <= cnt_q + 1'b1;
						last_q <= now_q;
					end
					state_q <= S_OUT;
				end
				S_RESTORE: begin
					cnt_q <= CW'(1);
					restart_q <= 1'b0;
					state_q <= S_OUT;
				end
				// one slot read a cycle from the expected slot upward
				S_SCAN: begin
					rv_s1 <= !(rv_s1 && rdata_q.valid);
					idx_s1 <= scan_idx_q;
					off_s1 <= scan_off_q;
					scan_idx_q <= scan_next;
					scan_off_q <= scan_off_q + 1'b1;
					if (rv_s1 && rdata_q.valid) begin
						state_q <= S_OUT;
						if (go) begin
							cnt_q <= cnt_q - 1'b1;
							res_hdl_q <= rdata_q.handle;
							res_seq_q <= pop_seq[rtpr_pkg::SEQ_W-1:0];
							exp_q <= pop_seq + 1'b1;
							base_q <= idx_next;
							res_status_q <= rtpr_pkg::ST_POPPED;
						end else begin
							res_status_q <= rtpr_pkg::ST_NONE;
						end
					end
				end
				// hand the result to the output register
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q <= res_status_q;
						m_tdata_q <= OUT_W'({cnt_q, res_flushed_q, res_seq_q, res_hdl_q});
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- sv/rtpr_checker.sv -----
// port-level checks of the rtp reorder buffer, bound to the top level
module rtpr_checker #(
	parameter int OUT_W = 48
) (
	input logic clk,
	input logic arst_n,
	input logic [OUT_W-1:0] m_tdata,
	input logic [2:0] m_tuser,
	input logic m_tvalid,
	input logic m_tready,
	input logic pready
);

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// a flush is reported exactly with restart and timeout results
	a_flush: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[32] == (m_tuser == rtpr_pkg::ST_RESTARTED ||
			m_tuser == rtpr_pkg::ST_TIMEOUT)))
		else $error("flushed flag does not match status");

	// a restart leaves exactly the new packet, a timeout leaves none
	a_restart_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == rtpr_pkg::ST_RESTARTED || m_tuser == rtpr_pkg::ST_TIMEOUT)
		|-> (m_tdata[OUT_W-1:33] == ((m_tuser == rtpr_pkg::ST_RESTARTED) ?
			(OUT_W - 33)'(1) : (OUT_W - 33)'(0))))
		else $error("stored count wrong after flush");

	// only a pop carries a handle and sequence
	a_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != rtpr_pkg::ST_POPPED) |-> (m_tdata[31:0] == 32'd0))
		else $error("handle or sequence set on a result that is not a pop");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("register port stalled");

endmodule

bind rtp_reorder_buffer_core rtpr_checker #(
	.OUT_W(((33 + $clog2(DEPTH + 1) + 7) / 8) * 8)
) u_rtpr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.pready(pready)
);
